### hw/rtl/c3dc_pkg.sv
package c3dc_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int HEIGHT_LIMIT = 1024;
   localparam int ROW_BITS     = 10;
   localparam int DIM_BITS     = 11;
   localparam int WCMP_BITS    = (COL_BITS + 1 > DIM_BITS) ? COL_BITS + 1 : DIM_BITS;
   localparam int HCMP_BITS    = DIM_BITS;
   localparam int COEF_BITS    = 16;
   localparam int PIX_BITS     = 8;
   localparam int PROD_BITS    = COEF_BITS + PIX_BITS + 1;
   localparam int SUM_BITS     = PROD_BITS + 4;
   localparam int DVS_BITS     = 16;
   localparam int DIV_BITS     = SUM_BITS + DVS_BITS;
   localparam int COEF_ROW_BITS = 48;
   localparam int TAPS         = 9;
   localparam int TAP_BITS     = 4;
   localparam int QBITS        = 8;
   localparam int QBIT_BITS    = 3;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_DATA_BITS = 64;

   typedef enum logic [2:0] {
      REG_COEF_TOP = 3'd0,
      REG_COEF_MID = 3'd1,
      REG_COEF_BOT = 3'd2,
      REG_DIVISOR  = 3'd3,
      REG_WIDTH    = 3'd4,
      REG_HEIGHT   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic                 accept;
      logic                 update;
      logic                 mac_en;
      logic [TAP_BITS-1:0]  tap;
      logic                 div_init;
      logic                 div_step;
      logic [QBIT_BITS-1:0] div_bit;
      logic                 load_out;
      logic                 clear_en;
      logic [COL_BITS-1:0]  clear_addr;
   } cmd_type;

   typedef struct packed {
      logic produce;
      logic div_early;
      logic out_free;
   } sts_type;

   function automatic logic signed [COEF_BITS-1:0] coef_slot(
      input logic [COEF_ROW_BITS-1:0] row,
      input logic [1:0]               slot
   );
      coef_slot = $signed(row[slot*16 +: COEF_BITS]);
   endfunction

endpackage

### hw/rtl/c3dc_ctrl.sv
module c3dc_ctrl
   import c3dc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MAC,
      ST_DIV_INIT,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [COL_BITS-1:0]  clear_ff, clear_in;
   logic [TAP_BITS-1:0]  tap_ff, tap_in;
   logic [QBIT_BITS-1:0] bit_ff, bit_in;

   always_comb begin
      state_in = state_ff;
      clear_in = clear_ff;
      tap_in   = tap_ff;
      bit_in   = bit_ff;
      cmd      = '0;
      cmd.tap        = tap_ff;
      cmd.div_bit    = bit_ff;
      cmd.clear_addr = clear_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            clear_in = clear_ff + 1'b1;
            if (clear_ff == COL_BITS'(MAX_WIDTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.update = 1'b1;
            tap_in = '0;
            state_in = sts.produce ? ST_MAC : ST_IDLE;
         end
         ST_MAC: begin
            cmd.mac_en = 1'b1;
            tap_in = tap_ff + 1'b1;
            if (tap_ff == TAP_BITS'(TAPS - 1)) begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            bit_in = QBIT_BITS'(QBITS - 1);
            state_in = sts.div_early ? ST_OUT : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clear_ff <= '0;
         tap_ff   <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
         tap_ff   <= tap_in;
         bit_ff   <= bit_in;
      end
   end

endmodule

### hw/rtl/c3dc_datapath.sv
module c3dc_datapath
   import c3dc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic [PIX_BITS-1:0]      pixel_value,
   input  logic [COEF_ROW_BITS-1:0] coef_top,
   input  logic [COEF_ROW_BITS-1:0] coef_mid,
   input  logic [COEF_ROW_BITS-1:0] coef_bot,
   input  logic [DVS_BITS-1:0]      divisor,
   input  logic [DIM_BITS-1:0]      image_width,
   input  logic [DIM_BITS-1:0]      image_height,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [31:0]              rsp_tdata,
   output logic                     rsp_tlast
);

   logic [2*PIX_BITS-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_BITS-1:0] rd_ff;
   logic [PIX_BITS-1:0]   pix_ff;
   logic [PIX_BITS-1:0]   win_ff [TAPS];
   logic [COL_BITS-1:0]   col_ff;
   logic [ROW_BITS-1:0]   row_ff;
   logic [ROW_BITS-1:0]   orow_ff;
   logic [ROW_BITS-1:0]   ocol_ff;
   logic                  last_ff;
   logic signed [SUM_BITS-1:0] acc_ff;
   logic [DIV_BITS-1:0]   rem_ff;
   logic [QBITS-1:0]      q_ff;
   logic                  valid_ff;
   logic [QBITS-1:0]      oq_ff;
   logic [ROW_BITS-1:0]   orow_out_ff;
   logic [ROW_BITS-1:0]   ocol_out_ff;
   logic                  olast_ff;

   logic [WCMP_BITS-1:0]  w_eff;
   logic [HCMP_BITS-1:0]  h_eff;
   logic                  col_end;
   logic                  row_end;
   logic signed [COEF_BITS-1:0] coefs [TAPS];
   logic signed [PROD_BITS-1:0] prod;
   logic [DVS_BITS-1:0]   dvs;
   logic [DIV_BITS-1:0]   dvs_top;
   logic [DIV_BITS-1:0]   dvs_sh;
   logic [DIV_BITS-1:0]   acc_u;
   logic                  acc_nonpos;

   always_comb begin
      logic [WCMP_BITS-1:0] wcfg;
      wcfg = WCMP_BITS'(image_width);
      if (wcfg < WCMP_BITS'(3)) begin
         w_eff = WCMP_BITS'(3);
      end else if (wcfg > WCMP_BITS'(MAX_WIDTH)) begin
         w_eff = WCMP_BITS'(MAX_WIDTH);
      end else begin
         w_eff = wcfg;
      end
      if (image_height < HCMP_BITS'(3)) begin
         h_eff = HCMP_BITS'(3);
      end else if (image_height > HCMP_BITS'(HEIGHT_LIMIT)) begin
         h_eff = HCMP_BITS'(HEIGHT_LIMIT);
      end else begin
         h_eff = image_height;
      end
   end

   assign col_end = (WCMP_BITS'(col_ff) + 1'b1) >= w_eff;
   assign row_end = (HCMP_BITS'(row_ff) + 1'b1) >= h_eff;

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         if (i < 3) begin
            coefs[i] = coef_slot(coef_top, 2'(i % 3));
         end else if (i < 6) begin
            coefs[i] = coef_slot(coef_mid, 2'(i % 3));
         end else begin
            coefs[i] = coef_slot(coef_bot, 2'(i % 3));
         end
      end
   end

   assign prod = coefs[cmd.tap] * $signed({1'b0, win_ff[cmd.tap]});

   assign dvs        = (divisor == '0) ? DVS_BITS'(1) : divisor;
   assign dvs_top    = DIV_BITS'(dvs) << QBITS;
   assign dvs_sh     = DIV_BITS'(dvs) << cmd.div_bit;
   assign acc_u      = DIV_BITS'(unsigned'(acc_ff));
   assign acc_nonpos = acc_ff[SUM_BITS-1] || (acc_ff == '0);

   assign sts.produce   = (row_ff >= ROW_BITS'(2)) && (col_ff >= COL_BITS'(2));
   assign sts.div_early = acc_nonpos || (acc_u >= dvs_top);
   assign sts.out_free  = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         line_mem[cmd.clear_addr] <= '0;
      end else if (cmd.update) begin
         line_mem[col_ff] <= {rd_ff[PIX_BITS-1:0], pix_ff};
      end
      if (cmd.accept) begin
         rd_ff  <= line_mem[col_ff];
         pix_ff <= pixel_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            win_ff[i] <= '0;
         end
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.update) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]     <= win_ff[r*3+1];
            win_ff[r*3 + 1] <= win_ff[r*3+2];
         end
         win_ff[2] <= rd_ff[2*PIX_BITS-1:PIX_BITS];
         win_ff[5] <= rd_ff[PIX_BITS-1:0];
         win_ff[8] <= pix_ff;
         if (col_end) begin
            col_ff <= '0;
            row_ff <= row_end ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         orow_ff <= row_ff - 1'b1;
         ocol_ff <= ROW_BITS'(col_ff - 1'b1);
         last_ff <= row_end && col_end;
      end
      if (cmd.mac_en) begin
         if (cmd.tap == '0) begin
            acc_ff <= SUM_BITS'(prod);
         end else begin
            acc_ff <= acc_ff + SUM_BITS'(prod);
         end
      end
      if (cmd.div_init) begin
         rem_ff <= acc_u;
         if (acc_nonpos) begin
            q_ff <= '0;
         end else if (acc_u >= dvs_top) begin
            q_ff <= '1;
         end else begin
            q_ff <= '0;
         end
      end else if (cmd.div_step) begin
         if (rem_ff >= dvs_sh) begin
            rem_ff <= rem_ff - dvs_sh;
            q_ff[cmd.div_bit] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         oq_ff       <= q_ff;
         orow_out_ff <= orow_ff;
         ocol_out_ff <= ocol_ff;
         olast_ff    <= last_ff;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0, ocol_out_ff, orow_out_ff, oq_ff};
   assign rsp_tlast  = olast_ff;

endmodule

### hw/rtl/conv3x3_divide_clamp_top.sv
// 3x3 convolution with divide and clamp over one 8-bit image plane.
// req_*: one pixel per transaction in raster order (tdata[7:0] pixel_value).
// rsp_*: one transaction per interior pixel; tdata holds filtered_value,
// out_row and out_col; tlast marks the last interior result of the plane.
// Border pixels give no rsp transaction.
// csr_*: APB register port, registers at byte address 8*index: coefficient
// rows top/mid/bot, divisor, image_width, image_height.
// Processing: a border pixel takes the accept and the line store read and
// update. An interior pixel takes the accept, the line store update, the
// nine taps through the single multiply-accumulate, divider setup, a
// restoring divider at one quotient bit per cycle, then the output register
// load; the divider is skipped when the result clamps.
// The output register holds a result while rsp_tready is low; the next
// pixel is still accepted and processed, and only waits before its own
// output load.
// After reset the line stores are cleared one entry per cycle, during
// which req_tready stays low; CSR writes are taken throughout.
module conv3x3_divide_clamp_top
   import c3dc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] pixel_value
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [31:0]              rsp_tdata,   // [7:0] filtered_value, [17:8] out_row,
                                                 // [27:18] out_col
   output logic                     rsp_tlast,   // frame_done
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [COEF_ROW_BITS-1:0] coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic [DVS_BITS-1:0]      divisor_ff;
   logic [DIM_BITS-1:0]      width_ff, height_ff;
   logic                     wr_en;
   reg_index_type            reg_idx;
   cmd_type                  cmd;
   sts_type                  sts;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff <= '0;
         coef_mid_ff <= COEF_ROW_BITS'(65536);
         coef_bot_ff <= '0;
         divisor_ff  <= DVS_BITS'(1);
         width_ff    <= DIM_BITS'(1024);
         height_ff   <= DIM_BITS'(1024);
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_COEF_TOP: coef_top_ff <= csr_pwdata[COEF_ROW_BITS-1:0];
            REG_COEF_MID: coef_mid_ff <= csr_pwdata[COEF_ROW_BITS-1:0];
            REG_COEF_BOT: coef_bot_ff <= csr_pwdata[COEF_ROW_BITS-1:0];
            REG_DIVISOR:  divisor_ff  <= csr_pwdata[DVS_BITS-1:0];
            REG_WIDTH:    width_ff    <= csr_pwdata[DIM_BITS-1:0];
            REG_HEIGHT:   height_ff   <= csr_pwdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_COEF_TOP: csr_prdata = CSR_DATA_BITS'(coef_top_ff);
         REG_COEF_MID: csr_prdata = CSR_DATA_BITS'(coef_mid_ff);
         REG_COEF_BOT: csr_prdata = CSR_DATA_BITS'(coef_bot_ff);
         REG_DIVISOR:  csr_prdata = CSR_DATA_BITS'(divisor_ff);
         REG_WIDTH:    csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_HEIGHT:   csr_prdata = CSR_DATA_BITS'(height_ff);
         default:      csr_prdata = '0;
      endcase
   end

   c3dc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   c3dc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .pixel_value  (req_tdata),
      .coef_top     (coef_top_ff),
      .coef_mid     (coef_mid_ff),
      .coef_bot     (coef_bot_ff),
      .divisor      (divisor_ff),
      .image_width  (width_ff),
      .image_height (height_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

### tb/conv3x3_checker.sv
module conv3x3_checker
   import c3dc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [7:0]               req_tdata,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [31:0]              rsp_tdata,
   input  logic                     rsp_tlast,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                     csr_pready,
   output int                       errors,
   output int                       pending
);

   typedef struct packed {
      logic [7:0]          value;
      logic [ROW_BITS-1:0] row;
      logic [ROW_BITS-1:0] col;
      logic                last;
   } filtered_pixel_type;

   logic [COEF_ROW_BITS-1:0] kernel_rows [3];
   logic [DVS_BITS-1:0]      divisor;
   logic [DIM_BITS-1:0]      width_reg;
   logic [DIM_BITS-1:0]      height_reg;
   logic [7:0]               line_older [MAX_WIDTH];
   logic [7:0]               line_newer [MAX_WIDTH];
   logic [7:0]               window [9];
   int                       row_pos;
   int                       col_pos;
   filtered_pixel_type       filtered_queue [$];

   function automatic int clamp_dim(input logic [DIM_BITS-1:0] v, input int hi);
      if (v < 3)
         return 3;
      if (v > hi)
         return hi;
      return int'(v);
   endfunction

   function automatic void predict_pixel(input logic [7:0] pix);
      int                 w;
      int                 h;
      logic [7:0]         top_pix;
      logic [7:0]         mid_pix;
      longint             sum;
      longint             quot;
      longint             dv;
      logic signed [15:0] k;
      filtered_pixel_type fp;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, HEIGHT_LIMIT);
      top_pix = line_older[col_pos];
      mid_pix = line_newer[col_pos];
      line_older[col_pos] = mid_pix;
      line_newer[col_pos] = pix;
      for (int r = 0; r < 3; r++) begin
         window[r*3]   = window[r*3+1];
         window[r*3+1] = window[r*3+2];
      end
      window[2] = top_pix;
      window[5] = mid_pix;
      window[8] = pix;
      if (row_pos >= 2 && col_pos >= 2) begin
         sum = 0;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
               k = kernel_rows[r][c*16 +: 16];
               sum += longint'(k) * longint'(window[r*3+c]);
            end
         dv = (divisor == 0) ? 1 : longint'(divisor);
         quot = sum / dv;
         if (quot > 255)
            quot = 255;
         if (quot < 0)
            quot = 0;
         fp.value = quot[7:0];
         fp.row   = ROW_BITS'(row_pos - 1);
         fp.col   = ROW_BITS'(col_pos - 1);
         fp.last  = (row_pos + 1 >= h) && (col_pos + 1 >= w);
         filtered_queue.push_back(fp);
      end
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   always @(posedge clock) begin
      filtered_pixel_type fp;
      filtered_pixel_type got;
      if (reset) begin
         kernel_rows[0] <= '0;
         kernel_rows[1] <= 48'h10000;
         kernel_rows[2] <= '0;
         divisor        <= DVS_BITS'(1);
         width_reg      <= DIM_BITS'(1024);
         height_reg     <= DIM_BITS'(1024);
         for (int i = 0; i < MAX_WIDTH; i++) begin
            line_older[i] = '0;
            line_newer[i] = '0;
         end
         for (int i = 0; i < 9; i++)
            window[i] = '0;
         row_pos = 0;
         col_pos = 0;
         filtered_queue.delete();
         errors  <= 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata[7:0];
            got.row   = rsp_tdata[17:8];
            got.col   = rsp_tdata[27:18];
            got.last  = rsp_tlast;
            if (filtered_queue.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               errors <= errors + 1;
            end else begin
               fp = filtered_queue.pop_front();
               if (fp !== got) begin
                  $display({"%0t: mismatch, expected val %0d row %0d col %0d last %0b,",
                            " actual val %0d row %0d col %0d last %0b"},
                           $time, fp.value, fp.row, fp.col, fp.last,
                           got.value, got.row, got.col, got.last);
                  errors <= errors + 1;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[5:3]))
               REG_COEF_TOP: kernel_rows[0] <= csr_pwdata[47:0];
               REG_COEF_MID: kernel_rows[1] <= csr_pwdata[47:0];
               REG_COEF_BOT: kernel_rows[2] <= csr_pwdata[47:0];
               REG_DIVISOR:  divisor        <= csr_pwdata[15:0];
               REG_WIDTH:    width_reg      <= csr_pwdata[10:0];
               REG_HEIGHT:   height_reg     <= csr_pwdata[10:0];
               default: ;
            endcase
         end
      end
      pending = filtered_queue.size();
   end

endmodule

### tb/tb.sv
module tb;
   import c3dc_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [7:0]               req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [31:0]              rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   int                       errors;
   int                       pending;
   int                       cycles = 0;
   int                       pixels_sent;
   logic                     calm;
   logic                     long_hold_done;

   conv3x3_divide_clamp_top uut (.*);

   conv3x3_checker chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .errors, .pending
   );

   initial clock = 0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: random stall bursts plus one long hold-off
   initial begin
      int hold;
      hold = 0;
      long_hold_done = 0;
      rsp_tready <= 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold = hold - 1;
            rsp_tready <= 0;
         end else if (!long_hold_done && cycles > 5000 && pending > 0 && req_tvalid) begin
            long_hold_done = 1;
            hold = 600;
            rsp_tready <= 0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 16) - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   task automatic send_pixel(input logic [7:0] pix);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         gap = $urandom_range(1, 16);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [63:0] val);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= CSR_ADDR_BITS'(idx) << 3;
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic configure(input logic [47:0] top, input logic [47:0] mid,
                            input logic [47:0] bot, input logic [15:0] dvs,
                            input logic [10:0] w, input logic [10:0] h);
      wait_drained();
      csr_write(REG_COEF_TOP, {16'h0, top});
      csr_write(REG_COEF_MID, {16'h0, mid});
      csr_write(REG_COEF_BOT, {16'h0, bot});
      csr_write(REG_DIVISOR, {48'h0, dvs});
      csr_write(REG_WIDTH, {53'h0, w});
      csr_write(REG_HEIGHT, {53'h0, h});
   endtask

   function automatic logic [47:0] random_kernel_row();
      logic [47:0] r;
      if ($urandom_range(0, 1)) begin
         r = 48'({$urandom(), $urandom()});
      end else begin
         for (int s = 0; s < 3; s++)
            r[s*16 +: 16] = 16'($signed($urandom_range(0, 8)) - 4);
      end
      return r;
   endfunction

   function automatic logic [7:0] random_pixel();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom());
      endcase
   endfunction

   initial begin
      logic [15:0] dvs;
      logic [10:0] w;
      logic [10:0] h;
      int          count;
      int          w_eff;
      int          h_eff;
      pixels_sent = 0;
      calm        = 0;
      reset       <= 1;
      req_tvalid  <= 0;
      req_tdata   <= 0;
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      csr_paddr   <= 0;
      csr_pwdata  <= 0;
      repeat (4) @(posedge clock);
      reset <= 0;

      // identity kernel on a 3x3 plane with extreme samples
      configure(48'h0, 48'h10000, 48'h0, 16'd1, 11'd3, 11'd3);
      for (int i = 0; i < 9; i++)
         send_pixel((i % 2) ? 8'hFF : 8'h00);
      // largest positive kernel, saturates high; out-of-range width and height
      configure(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                16'd1, 11'd1, 11'd0);
      for (int i = 0; i < 9; i++)
         send_pixel(8'hFF);
      // most negative kernel, zero divisor
      configure(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                16'd0, 11'd2, 11'd2);
      for (int i = 0; i < 9; i++)
         send_pixel(8'hFF);

      // width beyond the maximum, plane left unfinished
      configure(random_kernel_row(), random_kernel_row(), random_kernel_row(),
                16'd65535, 11'd2047, 11'd3);
      for (int i = 0; i < 40; i++)
         send_pixel(random_pixel());
      // tallest plane, left unfinished so the next setting starts mid-plane
      configure(random_kernel_row(), 48'h0001_0002_0001, random_kernel_row(),
                16'd9, 11'd6, 11'd2047);
      for (int i = 0; i < 40; i++)
         send_pixel(random_pixel());

      count = 0;
      while (count < 1000) begin
         case ($urandom_range(0, 4))
            0: dvs = 0;
            1: dvs = 1;
            2: dvs = 16'hFFFF;
            3: dvs = 16'($urandom_range(1, 32));
            default: dvs = 16'($urandom());
         endcase
         w = 11'($urandom_range(0, 10));
         h = 11'($urandom_range(0, 8));
         w_eff = (w < 3) ? 3 : w;
         h_eff = (h < 3) ? 3 : h;
         configure(random_kernel_row(), random_kernel_row(), random_kernel_row(), dvs, w, h);
         if ($urandom_range(0, 4) == 0)
            h_eff = $urandom_range(1, w_eff * h_eff);
         else
            h_eff = w_eff * h_eff * $urandom_range(1, 2);
         if (count > 850)
            calm = 1;
         for (int i = 0; i < h_eff; i++)
            send_pixel(random_pixel());
         count += h_eff;
      end
      req_tvalid <= 0;

      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### conv3x3_divide_clamp_top.f
hw/rtl/c3dc_pkg.sv
hw/rtl/c3dc_ctrl.sv
hw/rtl/c3dc_datapath.sv
hw/rtl/conv3x3_divide_clamp_top.sv
tb/conv3x3_checker.sv
tb/tb.sv
